[rtl/core/lrece_pkg.sv]
// ============================================================================
// lrece_pkg
// Shared types, constants and tables of the LR expression code emitter:
// parser action and goto tables, grammar rules and the x86-64 byte sequences.
// ============================================================================
package lrece_pkg;

    // Stack geometry
    localparam int unsigned STACK_DEPTH = 128;
    localparam int unsigned SP_W        = $clog2(STACK_DEPTH);
    localparam int unsigned VAL_W       = 64;
    localparam int unsigned NUM_W       = 63;

    // Per-token limits
    localparam int unsigned MAX_RESULTS = 28;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned MAX_ITER    = 16;
    localparam int unsigned ITER_W      = $clog2(MAX_ITER + 1);
    localparam int unsigned IDX_W       = 4;

    // Parser dimensions
    localparam int unsigned NUM_STATES  = 13;
    localparam int unsigned NUM_KINDS   = 7;
    localparam int unsigned NUM_LHS     = 3;
    localparam int unsigned NUM_RULES   = 8;
    localparam int unsigned NUM_PARAMS  = 3;

    // Token kinds
    localparam logic [2:0] TK_END    = 3'd0;
    localparam logic [2:0] TK_NUM    = 3'd1;
    localparam logic [2:0] TK_PARAM  = 3'd2;
    localparam logic [2:0] TK_ADDSUB = 3'd3;
    localparam logic [2:0] TK_MULDIV = 3'd4;
    localparam logic [2:0] TK_LPAREN = 3'd5;
    localparam logic [2:0] TK_RPAREN = 3'd6;

    // Rules that emit code
    localparam logic [2:0] RULE_NUM   = 3'd0;
    localparam logic [2:0] RULE_PARAM = 3'd1;
    localparam logic [2:0] RULE_MUL   = 3'd4;
    localparam logic [2:0] RULE_ADD   = 3'd6;

    typedef enum logic [1:0] {
        ACT_ERR   = 2'd0,
        ACT_ACC   = 2'd1,
        ACT_SHIFT = 2'd2,
        ACT_RED   = 2'd3
    } act_kind_t;

    typedef struct packed {
        logic [3:0] arg;
        act_kind_t  kind;
    } action_t;

    typedef enum logic [2:0] {
        SEQ_IMM   = 3'd0,
        SEQ_PARAM = 3'd1,
        SEQ_ADD   = 3'd2,
        SEQ_SUB   = 3'd3,
        SEQ_MUL   = 3'd4,
        SEQ_DIV   = 3'd5,
        SEQ_ACC   = 3'd6,
        SEQ_ERR   = 3'd7
    } seq_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       is_error;
        logic       accepted;
        logic       last_of_run;
    } result_t;

    function automatic logic [5:0] act_sh(input int unsigned n);
        return {4'(n), ACT_SHIFT};
    endfunction

    function automatic logic [5:0] act_rd(input int unsigned n);
        return {4'(n), ACT_RED};
    endfunction

    localparam logic [5:0] ACT_ACC_CODE = {4'd0, ACT_ACC};
    localparam logic [5:0] ACT_NONE     = {4'd0, ACT_ERR};

    // Columns: end, number, parameter, add, mul, lparen, rparen
    localparam logic [5:0] ACTION_TAB [NUM_STATES][NUM_KINDS] = '{
        '{ACT_NONE,  act_sh(2), act_sh(3), ACT_NONE,  ACT_NONE,  act_sh(1), ACT_NONE },
        '{ACT_NONE,  act_sh(2), act_sh(3), ACT_NONE,  ACT_NONE,  act_sh(1), ACT_NONE },
        '{act_rd(0), ACT_NONE,  ACT_NONE,  act_rd(0), act_rd(0), ACT_NONE,  act_rd(0)},
        '{act_rd(1), ACT_NONE,  ACT_NONE,  act_rd(1), act_rd(1), ACT_NONE,  act_rd(1)},
        '{act_rd(3), ACT_NONE,  ACT_NONE,  act_rd(3), act_rd(3), ACT_NONE,  act_rd(3)},
        '{act_rd(5), ACT_NONE,  ACT_NONE,  act_rd(5), act_sh(8), ACT_NONE,  act_rd(5)},
        '{ACT_ACC_CODE, ACT_NONE, ACT_NONE, act_sh(9), ACT_NONE, ACT_NONE,  ACT_NONE },
        '{ACT_NONE,  ACT_NONE,  ACT_NONE,  act_sh(9), ACT_NONE,  ACT_NONE,  act_sh(10)},
        '{ACT_NONE,  act_sh(2), act_sh(3), ACT_NONE,  ACT_NONE,  act_sh(1), ACT_NONE },
        '{ACT_NONE,  act_sh(2), act_sh(3), ACT_NONE,  ACT_NONE,  act_sh(1), ACT_NONE },
        '{act_rd(2), ACT_NONE,  ACT_NONE,  act_rd(2), act_rd(2), ACT_NONE,  act_rd(2)},
        '{act_rd(4), ACT_NONE,  ACT_NONE,  act_rd(4), act_rd(4), ACT_NONE,  act_rd(4)},
        '{act_rd(6), ACT_NONE,  ACT_NONE,  act_rd(6), act_sh(8), ACT_NONE,  act_rd(6)}
    };

    localparam logic [3:0] GOTO_TAB [NUM_STATES][NUM_LHS] = '{
        '{4'd4,  4'd5,  4'd6}, '{4'd4, 4'd5,  4'd7}, '{4'd0, 4'd0, 4'd0},
        '{4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0}, '{4'd0, 4'd0, 4'd0},
        '{4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0}, '{4'd11, 4'd0, 4'd0},
        '{4'd4,  4'd12, 4'd0}, '{4'd0, 4'd0,  4'd0}, '{4'd0, 4'd0, 4'd0},
        '{4'd0,  4'd0,  4'd0}
    };

    localparam logic [1:0] RULE_LEN [NUM_RULES] = '{2'd1, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd2};
    localparam logic [1:0] RULE_LHS [NUM_RULES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

    localparam logic [7:0] PARAM_BYTES [NUM_PARAMS] = '{8'h57, 8'h56, 8'h52};
    localparam logic [7:0] ADD_BYTES [5] = '{8'h58, 8'h48, 8'h01, 8'h04, 8'h24};
    localparam logic [7:0] SUB_BYTES [5] = '{8'h58, 8'h48, 8'h29, 8'h04, 8'h24};
    localparam logic [7:0] MUL_BYTES [10] = '{8'h58, 8'h48, 8'h0f, 8'haf, 8'h04,
                                              8'h24, 8'h48, 8'h89, 8'h04, 8'h24};
    localparam logic [7:0] DIV_BYTES [8] = '{8'h59, 8'h58, 8'h33, 8'hd2,
                                             8'h48, 8'hf7, 8'hf9, 8'h50};

    function automatic action_t action_lookup(input logic [3:0] st, input logic [2:0] kind);
        action_t a;
        a = action_t'(ACT_NONE);
        if (st < 4'(NUM_STATES) && kind < 3'(NUM_KINDS))
            a = action_t'(ACTION_TAB[st][kind]);
        return a;
    endfunction

    function automatic logic [3:0] goto_lookup(input logic [3:0] st, input logic [1:0] lhs);
        logic [3:0] g;
        g = 4'd0;
        if (st < 4'(NUM_STATES) && lhs < 2'(NUM_LHS))
            g = GOTO_TAB[st][lhs];
        return g;
    endfunction

    // Index of the final byte of each sequence
    function automatic logic [IDX_W-1:0] seq_last(input seq_t seq);
        logic [IDX_W-1:0] n;
        case (seq)
            SEQ_IMM:   n = IDX_W'(10);
            SEQ_PARAM: n = IDX_W'(0);
            SEQ_ADD:   n = IDX_W'(4);
            SEQ_SUB:   n = IDX_W'(4);
            SEQ_MUL:   n = IDX_W'(9);
            SEQ_DIV:   n = IDX_W'(7);
            SEQ_ACC:   n = IDX_W'(1);
            default:   n = IDX_W'(0);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input seq_t seq, input logic [IDX_W-1:0] idx,
                                            input logic [VAL_W-1:0] val);
        logic [IDX_W-1:0] k;
        logic [7:0]       b;
        k = idx - IDX_W'(2);
        case (seq)
            SEQ_IMM:
            begin
                if (idx == IDX_W'(0))
                    b = 8'h48;
                else if (idx == IDX_W'(1))
                    b = 8'hb8;
                else if (idx == IDX_W'(10))
                    b = 8'h50;
                else
                    b = val[{k[2:0], 3'b000} +: 8];
            end
            SEQ_PARAM:
            begin
                if (val < VAL_W'(NUM_PARAMS))
                    b = PARAM_BYTES[val[1:0]];
                else
                    b = PARAM_BYTES[NUM_PARAMS-1];
            end
            SEQ_ADD: b = ADD_BYTES[idx[2:0]];
            SEQ_SUB: b = SUB_BYTES[idx[2:0]];
            SEQ_MUL: b = MUL_BYTES[idx];
            SEQ_DIV: b = DIV_BYTES[idx[2:0]];
            SEQ_ACC: b = idx[0] ? 8'hc3 : 8'h58;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/lr_expression_code_emitter.sv]
// ============================================================================
// lr_expression_code_emitter
// Table-driven LR shift-reduce parser that turns expression tokens into
// x86-64 stack-machine code, one code byte per output word.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) takes one token word: token_kind,
//   number_value, op_variant, param_select. in_stall is high while a token
//   is being worked; the block takes one token at a time.
//   Output channel (out_valid / out_stall) gives one result word per code
//   byte, or one error word (is_error, code_byte zero). last_of_run marks the
//   final word caused by a token; a token that only shifts gives no word.
//   Sequence: a token that only shifts writes the stack and makes the block
//   ready again. Each reduction adds the stack-memory read and write-back
//   and then its emitted bytes; an accept or error adds only its bytes. A
//   token emits at most 28 bytes. The rate is set by the single read port
//   of the stack memories and by one byte leaving per cycle while the
//   receiver does not stall.
//   The final word of a token is held one stage until the token finishes, so
//   it can be flagged last_of_run.
//   Reset empties the parse stack (state 0 at the bottom) and drops any
//   words in flight. A stalled receiver holds the output word; the sequencer
//   then waits once its one-word holding stage is also full.
// ============================================================================
module lr_expression_code_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    token_kind,
    input  logic [lrece_pkg::NUM_W-1:0]   number_value,
    input  logic                          op_variant,
    input  logic [1:0]                    param_select,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    code_byte,
    output logic                          is_error,
    output logic                          accepted,
    output logic                          last_of_run
);
    import lrece_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_REDUCE = 5'b00100,
        S_EMIT   = 5'b01000,
        S_FINISH = 5'b10000
    } fsm_t;

    // Sequencer state
    fsm_t              state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [3:0]        top_reg, top_next;       // parser state on top of stack
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        rule_reg, rule_next;
    seq_t              seq_reg, seq_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              end_reg, end_next;       // sequence closes the token

    // Latched token
    logic [2:0]        kind_reg, kind_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic              var_reg, var_next;
    logic [1:0]        psel_reg, psel_next;

    // Holding stage and output register
    result_t           pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // Stack memories: parser states and token values
    logic [3:0]        state_mem [STACK_DEPTH];
    logic [VAL_W-1:0]  val_mem [STACK_DEPTH];
    logic [3:0]        rd_state_reg;
    logic [VAL_W-1:0]  rd_val_reg;

    logic              mem_we;
    logic [SP_W-1:0]   mem_wa;
    logic [3:0]        st_wd;
    logic [VAL_W-1:0]  vl_wd;
    logic              mem_re;
    logic [SP_W-1:0]   st_ra;
    logic [SP_W-1:0]   vl_ra;

    // Decode helpers
    action_t           act;
    logic [2:0]        act_rule;
    logic [1:0]        act_len;
    logic [SP_W:0]     sp_ext;
    logic [SP_W:0]     sp_inc;
    logic              overflow;
    logic              underflow;
    logic              bad_param;
    logic [VAL_W-1:0]  shift_val;
    logic [1:0]        red_len;
    logic [SP_W-1:0]   below_idx;
    logic [SP_W-1:0]   new_sp;
    logic [3:0]        below_state;
    logic [3:0]        goto_state;
    logic              o_free;
    result_t           new_res;
    result_t           last_res;

    assign act       = action_lookup(top_reg, kind_reg);
    assign act_rule  = act.arg[2:0];
    assign act_len   = RULE_LEN[act_rule];
    assign sp_ext    = {1'b0, sp_reg};
    assign sp_inc    = sp_ext + (SP_W+1)'(1);
    assign overflow  = (sp_inc >= (SP_W+1)'(STACK_DEPTH));
    assign underflow = (sp_ext < (SP_W+1)'(act_len));
    assign bad_param = (kind_reg == TK_PARAM) && (psel_reg >= 2'(NUM_PARAMS));

    always_comb
    begin
        case (kind_reg) inside
            TK_NUM:               shift_val = {1'b0, num_reg};
            TK_PARAM:             shift_val = VAL_W'(psel_reg);
            TK_ADDSUB, TK_MULDIV: shift_val = VAL_W'(var_reg);
            default:              shift_val = '0;
        endcase
    end

    // Reduction bookkeeping; the bottom entry is always taken as state 0
    assign red_len     = RULE_LEN[rule_reg];
    assign below_idx   = sp_reg - SP_W'(red_len);
    assign new_sp      = below_idx + SP_W'(1);
    assign below_state = (below_idx == '0) ? 4'd0 : rd_state_reg;
    assign goto_state  = goto_lookup(below_state, RULE_LHS[rule_reg]);

    assign o_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        new_res.code_byte   = (seq_reg == SEQ_ERR) ? 8'h00 : seq_byte(seq_reg, idx_reg, rd_val_reg);
        new_res.is_error    = (seq_reg == SEQ_ERR);
        new_res.accepted    = (seq_reg == SEQ_ACC);
        new_res.last_of_run = 1'b0;
        last_res             = pend_reg;
        last_res.last_of_run = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        iter_next       = iter_reg;
        cnt_next        = cnt_reg;
        rule_next       = rule_reg;
        seq_next        = seq_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        kind_next       = kind_reg;
        num_next        = num_reg;
        var_next        = var_reg;
        psel_next       = psel_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        mem_we = 1'b0;
        mem_wa = sp_inc[SP_W-1:0];
        st_wd  = act.arg;
        vl_wd  = shift_val;
        mem_re = 1'b0;
        st_ra  = sp_reg - SP_W'(act_len);
        vl_ra  = (act_len == 2'd1) ? sp_reg : sp_reg - SP_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = token_kind;
                    num_next   = number_value;
                    var_next   = op_variant;
                    psel_next  = param_select;
                    iter_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // Default: close the token with an error word and empty the stack
                seq_next = SEQ_ERR;
                idx_next = '0;
                end_next = 1'b1;
                if (iter_reg != ITER_W'(MAX_ITER))
                begin
                    case (act.kind)
                        ACT_SHIFT:
                        begin
                            if (!overflow && !bad_param)
                            begin
                                mem_we     = 1'b1;
                                sp_next    = sp_inc[SP_W-1:0];
                                top_next   = act.arg;
                                state_next = S_FINISH;
                            end
                        end
                        ACT_RED:
                        begin
                            if (!underflow)
                            begin
                                mem_re     = 1'b1;
                                rule_next  = act_rule;
                                state_next = S_REDUCE;
                            end
                        end
                        ACT_ACC: seq_next = SEQ_ACC;
                        default: seq_next = SEQ_ERR;
                    endcase
                end
                if (state_next == S_DECIDE)
                begin
                    sp_next    = '0;
                    top_next   = 4'd0;
                    state_next = S_EMIT;
                end
            end

            S_REDUCE:
            begin
                // Write back the goto state, clear the value slot
                mem_we    = 1'b1;
                mem_wa    = new_sp;
                st_wd     = goto_state;
                vl_wd     = '0;
                sp_next   = new_sp;
                top_next  = goto_state;
                iter_next = iter_reg + ITER_W'(1);
                idx_next  = '0;
                end_next  = 1'b0;
                state_next = S_EMIT;
                case (rule_reg)
                    RULE_NUM:   seq_next = SEQ_IMM;
                    RULE_PARAM: seq_next = SEQ_PARAM;
                    RULE_MUL:   seq_next = rd_val_reg[0] ? SEQ_DIV : SEQ_MUL;
                    RULE_ADD:   seq_next = rd_val_reg[0] ? SEQ_SUB : SEQ_ADD;
                    default:    state_next = S_DECIDE;
                endcase
            end

            S_EMIT:
            begin
                if (!pend_valid_reg || o_free)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (cnt_reg < CNT_W'(MAX_RESULTS))
                    begin
                        // Advance: new byte into the holding stage, held one out
                        pend_next       = new_res;
                        pend_valid_next = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                    end
                    if (idx_reg == seq_last(seq_reg))
                        state_next = end_reg ? S_FINISH : S_DECIDE;
                end
            end

            S_FINISH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (o_free)
                begin
                    out_next        = last_res;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            top_reg        <= 4'd0;
            iter_reg       <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            end_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            top_reg        <= top_next;
            iter_reg       <= iter_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg <= rule_next;
        seq_reg  <= seq_next;
        kind_reg <= kind_next;
        num_reg  <= num_next;
        var_reg  <= var_next;
        psel_reg <= psel_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Stack memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            state_mem[mem_wa] <= st_wd;
            val_mem[mem_wa]   <= vl_wd;
        end
        if (mem_re)
        begin
            rd_state_reg <= state_mem[st_ra];
            rd_val_reg   <= val_mem[vl_ra];
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign code_byte   = out_reg.code_byte;
    assign is_error    = out_reg.is_error;
    assign accepted    = out_reg.accepted;
    assign last_of_run = out_reg.last_of_run;

endmodule

[tb/emitted_code_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emitted_code_checker
// Watches the token and code-byte channels of the LR expression code emitter.
// It runs its own shift-reduce parser on every accepted token word, queues
// the code bytes that token must produce, and compares each accepted output
// word with the oldest queued one.
// ----------------------------------------------------------------------------
module emitted_code_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    token_kind,
    input  logic [lrece_pkg::NUM_W-1:0]   number_value,
    input  logic                          op_variant,
    input  logic [1:0]                    param_select,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    code_byte,
    input  logic                          is_error,
    input  logic                          accepted,
    input  logic                          last_of_run,
    output int                            fail_count,
    output int                            words_due
);

    import lrece_pkg::*;

    // Grammar rules
    localparam logic [2:0] R_FACTOR_NUM   = 3'd0;
    localparam logic [2:0] R_FACTOR_PARAM = 3'd1;
    localparam logic [2:0] R_FACTOR_PAREN = 3'd2;
    localparam logic [2:0] R_TERM_FACTOR  = 3'd3;
    localparam logic [2:0] R_TERM_MUL     = 3'd4;
    localparam logic [2:0] R_EXPR_TERM    = 3'd5;
    localparam logic [2:0] R_EXPR_ADD     = 3'd6;
    localparam logic [2:0] R_START        = 3'd7;

    // Opcode bytes and sequences, first byte in the top bits
    localparam logic [7:0]  OP_REX_W       = 8'h48;
    localparam logic [7:0]  OP_MOV_RAX_IMM = 8'hb8;
    localparam logic [7:0]  OP_PUSH_RAX    = 8'h50;
    localparam logic [7:0]  OP_POP_RAX     = 8'h58;
    localparam logic [7:0]  OP_RET         = 8'hc3;
    localparam logic [7:0]  OP_PUSH_RDI    = 8'h57;
    localparam logic [7:0]  OP_PUSH_RSI    = 8'h56;
    localparam logic [7:0]  OP_PUSH_RDX    = 8'h52;
    localparam logic [39:0] ADD_SEQ = 40'h58_48_01_04_24;
    localparam logic [39:0] SUB_SEQ = 40'h58_48_29_04_24;
    localparam logic [79:0] MUL_SEQ = 80'h58_48_0f_af_04_24_48_89_04_24;
    localparam logic [63:0] DIV_SEQ = 64'h59_58_33_d2_48_f7_f9_50;

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        act_kind_t  what;
        logic [3:0] arg;
    } parse_move_t;

    logic [3:0]  state_stack [STACK_DEPTH];
    logic [63:0] value_stack [STACK_DEPTH];
    int unsigned stack_top;

    result_t code_words_due [$];
    result_t token_words [$];
    int      fails;

    function automatic parse_move_t shift_to(input logic [3:0] s);
        parse_move_t m;
        m.what = ACT_SHIFT;
        m.arg  = s;
        return m;
    endfunction

    function automatic parse_move_t reduce_by(input logic [2:0] r);
        parse_move_t m;
        m.what = ACT_RED;
        m.arg  = {1'b0, r};
        return m;
    endfunction

    function automatic parse_move_t next_move(input logic [3:0] st, input logic [2:0] kind);
        parse_move_t m;
        logic        follow;
        m.what = ACT_ERR;
        m.arg  = 4'd0;
        follow = (kind == TK_END || kind == TK_ADDSUB || kind == TK_MULDIV ||
                  kind == TK_RPAREN);
        case (st)
            4'd0, 4'd1, 4'd8, 4'd9:
            begin
                if (kind == TK_NUM)
                    m = shift_to(4'd2);
                else if (kind == TK_PARAM)
                    m = shift_to(4'd3);
                else if (kind == TK_LPAREN)
                    m = shift_to(4'd1);
            end
            4'd2:  if (follow) m = reduce_by(R_FACTOR_NUM);
            4'd3:  if (follow) m = reduce_by(R_FACTOR_PARAM);
            4'd10: if (follow) m = reduce_by(R_FACTOR_PAREN);
            4'd4:  if (follow) m = reduce_by(R_TERM_FACTOR);
            4'd11: if (follow) m = reduce_by(R_TERM_MUL);
            4'd5, 4'd12:
            begin
                if (kind == TK_MULDIV)
                    m = shift_to(4'd8);
                else if (follow)
                    m = reduce_by(st == 4'd5 ? R_EXPR_TERM : R_EXPR_ADD);
            end
            4'd6:
            begin
                if (kind == TK_END)
                    m.what = ACT_ACC;
                else if (kind == TK_ADDSUB)
                    m = shift_to(4'd9);
            end
            4'd7:
            begin
                if (kind == TK_ADDSUB)
                    m = shift_to(4'd9);
                else if (kind == TK_RPAREN)
                    m = shift_to(4'd10);
            end
            default: ;
        endcase
        return m;
    endfunction

    // Drop bytes beyond the per-token limit
    function automatic void emit(input logic [7:0] b, input logic err, input logic acc);
        result_t w;
        w.code_byte   = b;
        w.is_error    = err;
        w.accepted    = acc;
        w.last_of_run = 1'b0;
        if (token_words.size() < MAX_RESULTS)
            token_words.push_back(w);
    endfunction

    function automatic void emit_seq(input logic [79:0] seq, input int n);
        for (int i = 0; i < n; i++)
            emit(seq[8*(n-1-i) +: 8], 1'b0, 1'b0);
    endfunction

    function automatic void clear_stack();
        stack_top      = 0;
        state_stack[0] = 4'd0;
        value_stack[0] = 64'd0;
    endfunction

    task automatic parse_token(input logic [2:0] kind, input logic [NUM_W-1:0] num,
                               input logic op_bit, input logic [1:0] psel);
        parse_move_t mv;
        logic [3:0]  cur;
        logic [3:0]  below;
        logic [3:0]  next_state;
        logic [2:0]  rule;
        logic [63:0] v;
        int unsigned top, len, base, b1, pass;
        logic        settled, fault;
        token_words.delete();
        settled = 1'b0;
        for (pass = 0; pass < MAX_ITER && !settled; pass++) begin
            top   = stack_top;
            cur   = (top < STACK_DEPTH) ? state_stack[top] : 4'd13;
            mv    = next_move(cur, kind);
            fault = 1'b0;
            case (mv.what)
                ACT_SHIFT:
                begin
                    if (top + 1 >= STACK_DEPTH || (kind == TK_PARAM && psel == 2'd3)) begin
                        fault = 1'b1;
                    end
                    else begin
                        case (kind)
                            TK_NUM:              v = {1'b0, num};
                            TK_PARAM:            v = {62'd0, psel};
                            TK_ADDSUB, TK_MULDIV: v = {63'd0, op_bit};
                            default:             v = 64'd0;
                        endcase
                        stack_top            = top + 1;
                        state_stack[top + 1] = mv.arg;
                        value_stack[top + 1] = v;
                        settled              = 1'b1;
                    end
                end
                ACT_RED:
                begin
                    rule = mv.arg[2:0];
                    case (rule)
                        R_FACTOR_PAREN, R_TERM_MUL, R_EXPR_ADD: len = 3;
                        R_START:                                len = 2;
                        default:                                len = 1;
                    endcase
                    if (top < len) begin
                        fault = 1'b1;
                    end
                    else begin
                        base = top - len + 1;
                        b1   = (base + 1 < STACK_DEPTH) ? base + 1 : base;
                        case (rule)
                            R_FACTOR_NUM:
                            begin
                                v = value_stack[base];
                                emit(OP_REX_W, 1'b0, 1'b0);
                                emit(OP_MOV_RAX_IMM, 1'b0, 1'b0);
                                for (int i = 0; i < 8; i++)
                                    emit(v[8*i +: 8], 1'b0, 1'b0);
                                emit(OP_PUSH_RAX, 1'b0, 1'b0);
                            end
                            R_FACTOR_PARAM:
                            begin
                                v = value_stack[base];
                                if (v == 64'd0)
                                    emit(OP_PUSH_RDI, 1'b0, 1'b0);
                                else if (v == 64'd1)
                                    emit(OP_PUSH_RSI, 1'b0, 1'b0);
                                else
                                    emit(OP_PUSH_RDX, 1'b0, 1'b0);
                            end
                            R_TERM_MUL:
                            begin
                                if (value_stack[b1][0])
                                    emit_seq(80'(DIV_SEQ), 8);
                                else
                                    emit_seq(MUL_SEQ, 10);
                            end
                            R_EXPR_ADD:
                            begin
                                if (value_stack[b1][0])
                                    emit_seq(80'(SUB_SEQ), 5);
                                else
                                    emit_seq(80'(ADD_SEQ), 5);
                            end
                            default: ;
                        endcase
                        below = state_stack[top - len];
                        case (rule)
                            R_FACTOR_NUM, R_FACTOR_PARAM, R_FACTOR_PAREN:
                                next_state = (below == 4'd8) ? 4'd11 :
                                             (below <= 4'd1 || below == 4'd9) ? 4'd4 : 4'd0;
                            R_TERM_FACTOR, R_TERM_MUL:
                                next_state = (below == 4'd9) ? 4'd12 :
                                             (below <= 4'd1) ? 4'd5 : 4'd0;
                            default:
                                next_state = (below == 4'd0) ? 4'd6 :
                                             (below == 4'd1) ? 4'd7 : 4'd0;
                        endcase
                        stack_top         = base;
                        state_stack[base] = next_state;
                        value_stack[base] = 64'd0;
                    end
                end
                ACT_ACC:
                begin
                    emit(OP_POP_RAX, 1'b0, 1'b1);
                    emit(OP_RET, 1'b0, 1'b1);
                    clear_stack();
                    settled = 1'b1;
                end
                default: fault = 1'b1;
            endcase
            if (fault) begin
                emit(8'h00, 1'b1, 1'b0);
                clear_stack();
                settled = 1'b1;
            end
        end
        if (!settled) begin
            emit(8'h00, 1'b1, 1'b0);
            clear_stack();
        end
        if (token_words.size() > 0)
            token_words[token_words.size() - 1].last_of_run = 1'b1;
        foreach (token_words[i])
            code_words_due.push_back(token_words[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            code_words_due.delete();
            clear_stack();
            fails      = 0;
            fail_count <= 0;
            words_due  <= 0;
        end
        else begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                got.code_byte   = code_byte;
                got.is_error    = is_error;
                got.accepted    = accepted;
                got.last_of_run = last_of_run;
                if (code_words_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected word: expected none, got byte %h err %b acc %b last %b",
                                 $time, got.code_byte, got.is_error, got.accepted,
                                 got.last_of_run);
                end
                else begin
                    want = code_words_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("%0t: word mismatch: expected byte %h err %b acc %b last %b, got byte %h err %b acc %b last %b",
                                     $time, want.code_byte, want.is_error, want.accepted,
                                     want.last_of_run, got.code_byte, got.is_error,
                                     got.accepted, got.last_of_run);
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                parse_token(token_kind, number_value, op_variant, param_select);
            fail_count <= fails;
            words_due  <= code_words_due.size();
        end
    end

endmodule

[tb/tb_lr_expression_code_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lr_expression_code_emitter
// Feeds expression tokens into the LR code emitter and gives the verdict.
// A directed set covers each operation, the value extremes and the error
// paths; a stack-overflow run follows, then random expressions mixed with
// broken sequences and noise tokens. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_lr_expression_code_emitter;

    import lrece_pkg::*;

    localparam logic [2:0]       TK_UNUSED    = 3'd7;     // kind with no meaning
    localparam logic [NUM_W-1:0] NUM_MAX      = '1;
    localparam int               RANDOM_ITEMS = 100;
    localparam int               TAIL_CYCLES  = 64;
    localparam int               CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {
        RX_OPEN,     // never stall
        RX_LIGHT,    // stall about one cycle in four
        RX_HEAVY     // stall most cycles
    } rx_mode_t;

    typedef struct {
        logic [2:0]       kind;
        logic [NUM_W-1:0] num;
        logic             op;
        logic [1:0]       psel;
    } token_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [2:0]       token_kind   = TK_END;
    logic [NUM_W-1:0] number_value = '0;
    logic             op_variant   = 1'b0;
    logic [1:0]       param_select = 2'd0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [7:0]       code_byte;
    logic             is_error;
    logic             accepted;
    logic             last_of_run;

    int       fail_count;
    int       words_due;
    int       burst_left = 0;
    int       cycle_count = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_mode_left = 0;
    token_t   plan [$];

    lr_expression_code_emitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .token_kind   (token_kind),
        .number_value (number_value),
        .op_variant   (op_variant),
        .param_select (param_select),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_byte    (code_byte),
        .is_error     (is_error),
        .accepted     (accepted),
        .last_of_run  (last_of_run)
    );

    emitted_code_checker code_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .token_kind   (token_kind),
        .number_value (number_value),
        .op_variant   (op_variant),
        .param_select (param_select),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_byte    (code_byte),
        .is_error     (is_error),
        .accepted     (accepted),
        .last_of_run  (last_of_run),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops words
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: switch between open, light and heavy stall patterns so the
    // output side sees both long free runs and long back-pressure stretches.
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(20, 200);
        end
        else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:  out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Mix of zero, maximum, small and full-width random values
    function automatic logic [NUM_W-1:0] rand_number();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return NUM_MAX;
            2:       return NUM_W'($urandom_range(0, 255));
            default: return r[NUM_W-1:0];
        endcase
    endfunction

    function automatic token_t tok(input logic [2:0] kind, input logic [NUM_W-1:0] num,
                                   input logic op, input logic [1:0] psel);
        token_t t;
        t.kind = kind;
        t.num  = num;
        t.op   = op;
        t.psel = psel;
        return t;
    endfunction

    // Any kind, any field values, bad parameter selects included
    function automatic token_t noise_tok();
        return tok(3'($urandom_range(0, 7)), rand_number(), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
    endfunction

    // Well-formed expression: terms joined by add/sub, factors by mul/div,
    // factors are numbers, parameters or a bracketed expression.
    function automatic void build_factor(input int level);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            plan.push_back(tok(TK_NUM, rand_number(), 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3))));
        end
        else if (pick < 8 || level >= 2) begin
            plan.push_back(tok(TK_PARAM, rand_number(), 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 2))));
        end
        else begin
            plan.push_back(tok(TK_LPAREN, rand_number(), 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3))));
            build_expr(level + 1);
            plan.push_back(tok(TK_RPAREN, rand_number(), 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3))));
        end
    endfunction

    function automatic void build_term(input int level);
        int factors;
        factors = $urandom_range(1, 3);
        for (int i = 0; i < factors; i++) begin
            if (i > 0)
                plan.push_back(tok(TK_MULDIV, rand_number(), 1'($urandom_range(0, 1)),
                                   2'($urandom_range(0, 3))));
            build_factor(level);
        end
    endfunction

    function automatic void build_expr(input int level);
        int terms;
        terms = $urandom_range(1, 3);
        for (int i = 0; i < terms; i++) begin
            if (i > 0)
                plan.push_back(tok(TK_ADDSUB, rand_number(), 1'($urandom_range(0, 1)),
                                   2'($urandom_range(0, 3))));
            build_term(level);
        end
    endfunction

    // Present one token word and hold it until accepted. Bursts of random
    // length end in a random gap, sometimes none, so tokens also arrive
    // back to back.
    task automatic drive_token(input token_t t);
        int gap;
        in_valid     <= 1'b1;
        token_kind   <= t.kind;
        number_value <= t.num;
        op_variant   <= t.op;
        param_select <= t.psel;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the sender off until every queued code word has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial begin
        int choice;
        int idx;
        int random_tokens;
        bit mid_pause_done;
        random_tokens  = 0;
        mid_pause_done = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest and smallest immediates
        drive_token(tok(TK_NUM, NUM_MAX, 1'b1, 2'd3));
        drive_token(tok(TK_END, NUM_MAX, 1'b1, 2'd3));
        drive_token(tok(TK_NUM, '0, 1'b0, 2'd0));
        drive_token(tok(TK_END, '0, 1'b0, 2'd0));
        // x + y * z: all three parameters, add and multiply
        drive_token(tok(TK_PARAM, rand_number(), 1'b1, 2'd0));
        drive_token(tok(TK_ADDSUB, rand_number(), 1'b0, 2'd3));
        drive_token(tok(TK_PARAM, rand_number(), 1'b0, 2'd1));
        drive_token(tok(TK_MULDIV, rand_number(), 1'b0, 2'd2));
        drive_token(tok(TK_PARAM, rand_number(), 1'b1, 2'd2));
        drive_token(tok(TK_END, rand_number(), 1'b1, 2'd1));
        // ( 5 - 7 / y ): brackets, subtract and divide
        drive_token(tok(TK_LPAREN, rand_number(), 1'b1, 2'd3));
        drive_token(tok(TK_NUM, NUM_W'(5), 1'b1, 2'd2));
        drive_token(tok(TK_ADDSUB, rand_number(), 1'b1, 2'd0));
        drive_token(tok(TK_NUM, NUM_W'(7), 1'b0, 2'd3));
        drive_token(tok(TK_MULDIV, rand_number(), 1'b1, 2'd1));
        drive_token(tok(TK_PARAM, rand_number(), 1'b0, 2'd1));
        drive_token(tok(TK_RPAREN, rand_number(), 1'b0, 2'd2));
        drive_token(tok(TK_END, rand_number(), 1'b0, 2'd0));
        // Parse errors: undefined kind, empty expression, bad parameter
        drive_token(tok(TK_UNUSED, rand_number(), 1'b1, 2'd3));
        drive_token(tok(TK_END, rand_number(), 1'b0, 2'd1));
        drive_token(tok(TK_PARAM, rand_number(), 1'b1, 2'd3));
        // Error after reductions have already emitted code
        drive_token(tok(TK_NUM, NUM_W'(9), 1'b0, 2'd0));
        drive_token(tok(TK_RPAREN, rand_number(), 1'b1, 2'd2));

        drain_results();

        // Nest brackets until the parse stack overflows
        repeat (STACK_DEPTH)
            drive_token(tok(TK_LPAREN, rand_number(), 1'($urandom_range(0, 1)),
                            2'($urandom_range(0, 3))));

        // Mostly whole expressions, some with one token corrupted, some noise
        while (random_tokens < RANDOM_ITEMS) begin
            plan.delete();
            choice = $urandom_range(0, 9);
            if (choice < 9) begin
                build_expr(0);
                plan.push_back(tok(TK_END, rand_number(), 1'($urandom_range(0, 1)),
                                   2'($urandom_range(0, 3))));
                if (choice >= 7) begin
                    idx = $urandom_range(0, plan.size() - 1);
                    plan[idx] = noise_tok();
                end
            end
            else begin
                plan.push_back(noise_tok());
            end
            foreach (plan[i])
                drive_token(plan[i]);
            random_tokens += plan.size();
            if (!mid_pause_done && random_tokens >= RANDOM_ITEMS / 2) begin
                mid_pause_done = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && words_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
